// ----- src/sfhc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfhc_pkg: shared types and constants of the serial frame checker
// Word layouts, status codes, register indexes and CRC-16 constants.
// ----------------------------------------------------------------------------
package sfhc_pkg;

    // crc-16 (reflected) constants
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // shortest frame the checker accepts as a length setting
    localparam logic [7:0] MIN_LENGTH = 8'd4;

    // status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEN  = 3'd1;
    localparam logic [2:0] STATUS_BAD_ADDR = 3'd2;
    localparam logic [2:0] STATUS_BAD_FUNC = 3'd3;
    localparam logic [2:0] STATUS_BAD_CRC  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd0;
    localparam logic [1:0] CFG_STATION_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_FUNCTION_CODE   = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       block_end;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] computed_crc;
    } out_word_t;

    typedef struct packed {
        logic [7:0] expected_length;
        logic [7:0] station_address;
        logic [7:0] function_code;
    } cfg_t;

endpackage

// ----- src/serial_frame_header_crc_checker.sv -----
// ----------------------------------------------------------------------------
// serial_frame_header_crc_checker: frame header and crc-16 checker
// Checks length, address and function bytes and the trailing crc of a frame.
//
//   channel  | ports                       | word
//   ---------+-----------------------------+--------------------------------
//   input    | s_valid s_ready s_data      | rx_byte, block_end
//   result   | m_valid m_ready m_data      | status, computed_crc
//   config   | cfg_we cfg_index cfg_wdata  | 8-bit register write
//
// One input word per cycle while not stalled; each word is held in the input
// register, passes the check logic, and its result goes to the output register.
// Only the block_end word produces a result; the input register stalls only
// while a result waits in the output register and m_ready is low.
// Synchronous active-low reset clears frame state and loads register defaults.
// ----------------------------------------------------------------------------
module serial_frame_header_crc_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfhc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sfhc_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import sfhc_pkg::*;

    cfg_t      cfg_reg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t result;
    logic      out_free;
    logic      advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_length <= 8'd5;
            cfg_reg.station_address <= 8'd2;
            cfg_reg.function_code   <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXPECTED_LENGTH: cfg_reg.expected_length <= cfg_wdata;
                CFG_STATION_ADDRESS: cfg_reg.station_address <= cfg_wdata;
                CFG_FUNCTION_CODE:   cfg_reg.function_code   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    sfhc_frame_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .word_in (in_word_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_word_reg.block_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_word_reg.block_end) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an empty input register always takes a word
    a_empty_ready: assert property (@(posedge aclk)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // a processed block end always shows up as a result
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_word_reg.block_end |=> m_valid)
        else $error("block end word produced no result");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STATUS_BAD_CRC)
        else $error("undefined status code");

endmodule

// ----- src/sfhc_crc_byte.sv -----
// ----------------------------------------------------------------------------
// sfhc_crc_byte: one-byte crc-16 update
// Feeds eight bits of a byte into the reflected crc-16, unrolled.
// ----------------------------------------------------------------------------
module sfhc_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import sfhc_pkg::*;

    // eight shift and conditional xor steps
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = {1'b0, c[15:1]} ^ CRC_POLY;
            end else begin
                c = {1'b0, c[15:1]};
            end
        end
        crc_out = c;
    end

endmodule

// ----- src/sfhc_frame_check.sv -----
// ----------------------------------------------------------------------------
// sfhc_frame_check: per-frame state and header/crc checks
// Holds byte position, running crc and first error; builds the result word.
// ----------------------------------------------------------------------------
module sfhc_frame_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  sfhc_pkg::in_word_t  word_in,
    input  sfhc_pkg::cfg_t      cfg,
    output sfhc_pkg::out_word_t result
);
    import sfhc_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  len, len_m1, len_m2;
    logic [15:0] crc_fed;
    logic [7:0]  b;

    assign b = word_in.rx_byte;

    // effective length, clamped up to the minimum
    assign len    = (cfg.expected_length < MIN_LENGTH) ? MIN_LENGTH : cfg.expected_length;
    assign len_m1 = len - 8'd1;
    assign len_m2 = len - 8'd2;

    sfhc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (b),
        .crc_out (crc_fed)
    );

    // checks in priority order, first failure sticks
    always_comb begin
        err_next = err_reg;
        crc_next = crc_reg;
        if (pos_reg < len) begin
            if (err_reg == STATUS_OK) begin
                priority if (pos_reg == 8'd0 && b != len) begin
                    err_next = STATUS_BAD_LEN;
                end else if (pos_reg == 8'd1 && b != cfg.station_address) begin
                    err_next = STATUS_BAD_ADDR;
                end else if (pos_reg == 8'd2 && b != cfg.function_code) begin
                    err_next = STATUS_BAD_FUNC;
                end else if (pos_reg == len_m2 && b != crc_reg[7:0]) begin
                    err_next = STATUS_BAD_CRC;
                end else if (pos_reg == len_m1 && b != crc_reg[15:8]) begin
                    err_next = STATUS_BAD_CRC;
                end else begin
                    err_next = err_reg;
                end
            end
            if (pos_reg < len_m2) begin
                crc_next = crc_fed;
            end
        end
        // position saturates at the top
        pos_next = (pos_reg != 8'hFF) ? pos_reg + 8'd1 : pos_reg;
    end

    // result word for the last byte of a block
    always_comb begin
        result.computed_crc = crc_next;
        if (err_next == STATUS_OK && pos_next < len) begin
            result.status = STATUS_BAD_CRC;
        end else begin
            result.status = err_next;
        end
    end

    // frame state, cleared at block end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 8'd0;
            crc_reg <= CRC_INIT;
            err_reg <= STATUS_OK;
        end else if (advance) begin
            if (word_in.block_end) begin
                pos_reg <= 8'd0;
                crc_reg <= CRC_INIT;
                err_reg <= STATUS_OK;
            end else begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                err_reg <= err_next;
            end
        end
    end

    // block end restarts the frame
    a_end_clears: assert property (@(posedge aclk)
        advance && word_in.block_end |=> pos_reg == 8'd0 && crc_reg == CRC_INIT
                                          && err_reg == STATUS_OK)
        else $error("frame state not cleared after block end");

    // position counts bytes until it saturates
    a_pos_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !word_in.block_end && pos_reg != 8'hFF
        |=> pos_reg == $past(pos_reg) + 8'd1)
        else $error("byte position did not advance");

    // a recorded error is never overwritten within a frame
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !word_in.block_end && err_reg != STATUS_OK
        |=> err_reg == $past(err_reg))
        else $error("first error changed");

endmodule

// ----- bench/serial_frame_header_crc_checker_tb.sv -----
// ----------------------------------------------------------------------------
// serial_frame_header_crc_checker_tb: self-checking bench of the frame checker
// Feeds frames byte by byte over the input handshake, mirrors the header and
// crc-16 checks in a local predictor, and compares every status word against
// it. Directed frames cover each status code, then random phases follow.
// ----------------------------------------------------------------------------
module serial_frame_header_crc_checker_tb;
    import sfhc_pkg::*;

    localparam int WORD_TARGET  = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;

    // mirror of the register settings
    logic [7:0]  set_length;
    logic [7:0]  set_address;
    logic [7:0]  set_function;

    // predictor frame state
    logic [7:0]  frame_pos;
    logic [15:0] frame_crc;
    logic [2:0]  frame_error;
    logic        frame_saturated;

    out_word_t   status_expected[$];
    logic [7:0]  frame_bytes[$];
    int          frame_body_len;

    int          words_sent;
    int          results_checked;
    int          mismatch_count;
    int          settings_used;
    int          cycle_count;
    bit          quiet_phase;

    serial_frame_header_crc_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // reflected crc-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] effective_length(input logic [7:0] len);
        return (len < MIN_LENGTH) ? MIN_LENGTH : len;
    endfunction

    function automatic void clear_frame_state();
        frame_pos       = 8'd0;
        frame_crc       = CRC_INIT;
        frame_error     = STATUS_OK;
        frame_saturated = 1'b0;
    endfunction

    // header and crc checks for one accepted word
    function automatic void frame_check_step(input in_word_t w);
        logic [7:0] n;
        logic [2:0] err;
        out_word_t  r;
        n   = effective_length(set_length);
        err = frame_error;
        if (frame_pos < n) begin
            if (err == STATUS_OK) begin
                if (frame_pos == 8'd0 && w.rx_byte != n)
                    err = STATUS_BAD_LEN;
                else if (frame_pos == 8'd1 && w.rx_byte != set_address)
                    err = STATUS_BAD_ADDR;
                else if (frame_pos == 8'd2 && w.rx_byte != set_function)
                    err = STATUS_BAD_FUNC;
                else if (frame_pos == n - 8'd2 && w.rx_byte != frame_crc[7:0])
                    err = STATUS_BAD_CRC;
                else if (frame_pos == n - 8'd1 && w.rx_byte != frame_crc[15:8])
                    err = STATUS_BAD_CRC;
            end
            if (frame_pos < n - 8'd2)
                frame_crc = crc16_byte(frame_crc, w.rx_byte);
        end
        frame_error = err;
        if (frame_pos != 8'hFF) frame_pos = frame_pos + 8'd1;
        else                    frame_saturated = 1'b1;
        if (w.block_end) begin
            r.status       = (err == STATUS_OK && frame_pos < n) ? STATUS_BAD_CRC : err;
            r.computed_crc = frame_crc;
            status_expected.push_back(r);
            clear_frame_state();
        end
    endfunction

    // build a well-formed frame for the current settings
    function automatic void build_good_frame(input int excess);
        logic [7:0]  n;
        logic [7:0]  b;
        logic [15:0] crc;
        n   = effective_length(set_length);
        crc = CRC_INIT;
        frame_bytes.delete();
        for (int i = 0; i < n - 2; i++) begin
            if (i == 0)      b = n;
            else if (i == 1) b = set_address;
            else if (i == 2) b = set_function;
            else             b = 8'($urandom_range(0, 255));
            frame_bytes.push_back(b);
            crc = crc16_byte(crc, b);
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        frame_body_len = frame_bytes.size();
        repeat (excess) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // send one word, predict on acceptance
    task automatic send_word(input logic [7:0] value, input logic last);
        int       gap;
        in_word_t w;
        w.rx_byte   = value;
        w.block_end = last;
        gap = quiet_phase ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        frame_check_step(w);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_word(frame_bytes[i], i == frame_bytes.size() - 1);
            if (i < frame_body_len) words_sent++;
        end
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input int count);
        frame_bytes.delete();
        frame_bytes.push_back(b0);
        if (count > 1) frame_bytes.push_back(b1);
        if (count > 2) frame_bytes.push_back(b2);
        frame_body_len = count;
        send_frame();
    endtask

    // hold the sender until every status word is back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (status_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] len, input logic [7:0] addr,
                              input logic [7:0] func);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_LENGTH;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_index <= CFG_STATION_ADDRESS;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_index <= CFG_FUNCTION_CODE;
        cfg_wdata <= func;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        set_length   = len;
        set_address  = addr;
        set_function = func;
        settings_used++;
    endtask

    // good frame under reset settings, with trailing bytes ignored
    task automatic test_default_frame();
        build_good_frame(2);
        send_frame();
    endtask

    // each header byte failing in turn, and a block cut short
    task automatic test_header_checks();
        send_bytes(8'd6, 8'd0, 8'd0, 1);
        send_bytes(8'd5, 8'd3, 8'd0, 2);
        send_bytes(8'd5, 8'd2, 8'd1, 3);
        send_bytes(8'd5, 8'd2, 8'd0, 3);
    endtask

    // wrong crc high byte
    task automatic test_crc_check();
        build_good_frame(0);
        frame_bytes[frame_bytes.size() - 1] ^= 8'h01;
        send_frame();
    endtask

    // length setting below the minimum; byte two is both function and crc low
    task automatic test_short_length_setting();
        logic [15:0] crc;
        crc = crc16_byte(crc16_byte(CRC_INIT, MIN_LENGTH), 8'hFF);
        set_config(8'd0, 8'hFF, crc[7:0]);
        build_good_frame(0);
        send_frame();
        send_bytes(MIN_LENGTH, 8'hFF, crc[7:0] ^ 8'h80, 3);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // random settings and mostly well-formed frames
    task automatic test_random_frames();
        int          phase;
        int          frames;
        int          kind;
        int          r;
        logic [7:0]  len;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] crc;
        phase = 0;
        while (words_sent < WORD_TARGET) begin
            if (phase == 0) begin
                len  = 8'd255;
                addr = 8'h00;
                func = 8'hFF;
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0)      len = 8'($urandom_range(0, 3));
                else if (r == 1) len = 8'($urandom_range(33, 64));
                else             len = 8'($urandom_range(4, 12));
                addr = pick_byte();
                func = pick_byte();
                if (effective_length(len) == MIN_LENGTH && $urandom_range(0, 1) == 1) begin
                    crc  = crc16_byte(crc16_byte(CRC_INIT, MIN_LENGTH), addr);
                    func = crc[7:0];
                end
            end
            set_config(len, addr, func);
            quiet_phase = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                // longest frame, running past the byte counter's saturation
                build_good_frame(60);
                send_frame();
            end else begin
                frames = (effective_length(len) > 32) ? 2 : 8;
                repeat (frames) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 70) begin
                        build_good_frame(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
                    end else if (kind < 85) begin
                        build_good_frame(0);
                        r = $urandom_range(0, frame_bytes.size() - 1);
                        frame_bytes[r] ^= 8'($urandom_range(1, 255));
                    end else if (kind < 93) begin
                        build_good_frame(0);
                        r = $urandom_range(1, frame_bytes.size() - 1);
                        while (frame_bytes.size() > r) void'(frame_bytes.pop_back());
                        frame_body_len = r;
                    end else begin
                        frame_bytes.delete();
                        repeat ($urandom_range(1, 8))
                            frame_bytes.push_back(8'($urandom_range(0, 255)));
                        frame_body_len = frame_bytes.size();
                    end
                    send_frame();
                end
            end
            phase++;
        end
        quiet_phase = 1'b0;
        wait_results_drained();
    endtask

    // result side: random stall before each word
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each status word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_expected.size() == 0) begin
                $error("unexpected result: status=%0d computed_crc=%h",
                       m_data.status, m_data.computed_crc);
                mismatch_count++;
            end else begin
                if (m_data.status !== status_expected[0].status) begin
                    $error("status: expected %0d, got %0d",
                           status_expected[0].status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.computed_crc !== status_expected[0].computed_crc) begin
                    $error("computed_crc: expected %h, got %h",
                           status_expected[0].computed_crc, m_data.computed_crc);
                    mismatch_count++;
                end
                void'(status_expected.pop_front());
                results_checked++;
            end
        end
    end

    // run time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_EXPECTED_LENGTH;
        cfg_wdata       = 8'd0;
        quiet_phase     = 1'b0;
        words_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        settings_used   = 0;
        cycle_count     = 0;
        frame_body_len  = 0;
        set_length      = 8'd5;
        set_address     = 8'd2;
        set_function    = 8'd0;
        clear_frame_state();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_frame();
        test_header_checks();
        test_crc_check();
        test_short_length_setting();
        test_random_frames();

        $display("%0d frame bytes sent, %0d status words checked, %0d register settings",
                 words_sent, results_checked, settings_used);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sfhc_pkg.sv
src/sfhc_crc_byte.sv
src/sfhc_frame_check.sv
src/serial_frame_header_crc_checker.sv
bench/serial_frame_header_crc_checker_tb.sv
